FILE: src/psw_pkg.sv
// shared types and constants of the priority schedule wait-time block
// used by the controller, the datapath and the top level; depends on nothing

package psw_pkg;

    // capacity and length width
    localparam int MAX_JOBS    = 32;
    localparam int LENGTH_BITS = 16;

    // fixed field widths of the stream words
    localparam int IN_LEN_W = 16;
    localparam int NUM_W    = 6;
    localparam int OUT_LEN_W = 16;
    localparam int TIME_W   = 21;

    // derived widths
    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int LEN_W  = LENGTH_BITS;
    localparam int KEEP_W = (LENGTH_BITS < IN_LEN_W) ? LENGTH_BITS : IN_LEN_W;
    localparam int SUM_W  = LENGTH_BITS + CNT_W;
    localparam int TOT_W  = LENGTH_BITS + 2 * CNT_W;
    localparam int DIVC_W = $clog2(TOT_W + 1);

    // stream word widths, padded to whole bytes
    localparam int S_DATA_W = ((IN_LEN_W + 7) / 8) * 8;
    localparam int M_FIELD_W = NUM_W + OUT_LEN_W + 4 * TIME_W;
    localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // one stored job
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [LEN_W-1:0] len;
    } t_entry;

    // one result word before packing
    typedef struct packed {
        logic [NUM_W-1:0]     num;
        logic [OUT_LEN_W-1:0] len;
        logic [TIME_W-1:0]    wait_t;
        logic [TIME_W-1:0]    turn_t;
        logic [TIME_W-1:0]    wait_avg;
        logic [TIME_W-1:0]    avg_turn;
        logic                 dropped;
        logic                 last;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic load_en;
        logic sort_init;
        logic scan_rd;
        logic scan_cmp;
        logic swap_a;
        logic swap_b;
        logic sum_rd;
        logic sum_acc;
        logic div_start;
        logic div_turn;
        logic div_step;
        logic save_w;
        logic save_t;
        logic emit_init;
        logic emit_rd;
        logic emit_ld;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_last_acc;
        logic j_last;
        logic i_last;
        logic k_last;
        logic div_done;
        logic out_free;
    } t_status;

    // keep the low length bits of an incoming job
    function automatic logic [LEN_W-1:0] mask_len(input logic [IN_LEN_W-1:0] x);
        mask_len = LEN_W'(x[KEEP_W-1:0]);
    endfunction

endpackage

FILE: src/psw_ctrl.sv
// controller of the priority schedule wait-time block
// sequences load, sort, totals, divisions and emission; depends on psw_pkg

module psw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psw_pkg::t_status i_st,
    output psw_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SWAP_A,
        S_SWAP_B,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_START,
        S_DIVW_RUN,
        S_DIVT_RUN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;
    t_state n_state;

    // command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                o_cmd.load_en   = 1'b1;
                o_cmd.sort_init = i_st.in_last_acc;
                if (i_st.in_last_acc) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_st.j_last ? S_SWAP_A : S_SCAN_RD;
            end
            S_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state      = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state      = i_st.i_last ? S_SUM_RD : S_SCAN_RD;
            end
            S_SUM_RD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state       = i_st.k_last ? S_DIV_START : S_SUM_RD;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW_RUN;
            end
            S_DIVW_RUN: begin
                if (i_st.div_done) begin
                    o_cmd.save_w    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_turn  = 1'b1;
                    n_state         = S_DIVT_RUN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIVT_RUN: begin
                if (i_st.div_done) begin
                    o_cmd.save_t    = 1'b1;
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT_RD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_st.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    n_state       = i_st.k_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/psw_dp.sv
// datapath of the priority schedule wait-time block
// job memory, sort registers, totals, shared divider and output register; depends on psw_pkg

module psw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psw_pkg::t_cmd                 i_cmd,
    output psw_pkg::t_status              o_st,
    input  logic                          i_in_valid,
    input  logic [psw_pkg::IN_LEN_W-1:0]  i_in_len,
    input  logic                          i_in_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output psw_pkg::t_result              o_out
);

    // job memory
    psw_pkg::t_entry r_mem [psw_pkg::MAX_JOBS];
    psw_pkg::t_entry r_rd;

    // control state
    logic [psw_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_ovf;
    logic                       r_out_valid;

    // sort and pass registers
    logic [psw_pkg::IDX_W-1:0]  r_i;
    logic [psw_pkg::IDX_W-1:0]  r_j;
    logic [psw_pkg::IDX_W-1:0]  r_k;
    logic [psw_pkg::IDX_W-1:0]  r_pos;
    psw_pkg::t_entry            r_max;
    psw_pkg::t_entry            r_first;
    logic [psw_pkg::SUM_W-1:0]  r_sum;
    logic [psw_pkg::TOT_W-1:0]  r_totw;

    // divider registers
    logic [psw_pkg::TOT_W-1:0]  r_dq;
    logic [psw_pkg::CNT_W-1:0]  r_drem;
    logic [psw_pkg::DIVC_W-1:0] r_dcnt;
    logic [psw_pkg::TOT_W-1:0]  r_avg_w;
    logic [psw_pkg::TOT_W-1:0]  r_avg_t;
    psw_pkg::t_result           r_out;

    // memory port signals
    logic                       acc;
    logic                       store;
    logic                       we;
    logic [psw_pkg::IDX_W-1:0]  wa;
    psw_pkg::t_entry            wd;
    logic                       re;
    logic [psw_pkg::IDX_W-1:0]  ra;

    // divider step
    logic [psw_pkg::CNT_W:0]    d_t;
    logic [psw_pkg::CNT_W-1:0]  d_sub;
    logic                       d_ge;

    // memory port selection
    always_comb begin
        acc   = i_in_valid & i_cmd.load_en;
        store = acc & (r_cnt < psw_pkg::CNT_W'(psw_pkg::MAX_JOBS));
        we    = store | i_cmd.swap_a | i_cmd.swap_b;
        if (i_cmd.swap_a) begin
            wa = r_i;
            wd = r_max;
        end else if (i_cmd.swap_b) begin
            wa = r_pos;
            wd = r_first;
        end else begin
            wa     = r_cnt[psw_pkg::IDX_W-1:0];
            wd.num = psw_pkg::NUM_W'(r_cnt + psw_pkg::CNT_W'(1));
            wd.len = psw_pkg::mask_len(i_in_len);
        end
        re = i_cmd.scan_rd | i_cmd.sum_rd | i_cmd.emit_rd;
        ra = i_cmd.scan_rd ? r_j : r_k;
    end

    // memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rd <= r_mem[ra];
        end
    end

    // restoring divide by the job count, one quotient bit per step
    // the partial remainder stays below the count, so the difference fits CNT_W bits
    always_comb begin
        d_t   = {r_drem, r_dq[psw_pkg::TOT_W-1]};
        d_ge  = d_t >= {1'b0, r_cnt};
        d_sub = d_t[psw_pkg::CNT_W-1:0] - r_cnt;
    end

    // status to the controller
    always_comb begin
        o_st.in_last_acc = acc & i_in_last;
        o_st.j_last   = (psw_pkg::CNT_W'(r_j) + psw_pkg::CNT_W'(1)) == r_cnt;
        o_st.i_last   = (psw_pkg::CNT_W'(r_i) + psw_pkg::CNT_W'(1)) == r_cnt;
        o_st.k_last   = (psw_pkg::CNT_W'(r_k) + psw_pkg::CNT_W'(1)) == r_cnt;
        o_st.div_done = r_dcnt == '0;
        o_st.out_free = !r_out_valid | i_out_ready;
    end

    // job count, overflow flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (store) begin
                r_cnt <= r_cnt + psw_pkg::CNT_W'(1);
            end else if (acc) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.emit_ld && o_st.k_last) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.emit_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sort scan, swap, totals, divider and emission
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= '0;
            r_j <= '0;
        end
        // first strict maximum of places i and up
        if (i_cmd.scan_cmp) begin
            if (r_j == r_i) begin
                r_max   <= r_rd;
                r_first <= r_rd;
                r_pos   <= r_j;
            end else if (r_rd.len > r_max.len) begin
                r_max <= r_rd;
                r_pos <= r_j;
            end
            r_j <= r_j + psw_pkg::IDX_W'(1);
        end
        // next place, and clear the totals pass
        if (i_cmd.swap_b) begin
            r_i    <= r_i + psw_pkg::IDX_W'(1);
            r_j    <= r_i + psw_pkg::IDX_W'(1);
            r_k    <= '0;
            r_sum  <= '0;
            r_totw <= '0;
        end
        // total wait and total length over the ordered set
        if (i_cmd.sum_acc) begin
            r_totw <= r_totw + psw_pkg::TOT_W'(r_sum);
            r_sum  <= r_sum + psw_pkg::SUM_W'(r_rd.len);
            r_k    <= r_k + psw_pkg::IDX_W'(1);
        end
        // divider load and steps
        if (i_cmd.div_start) begin
            r_dq   <= i_cmd.div_turn ? r_totw + psw_pkg::TOT_W'(r_sum) : r_totw;
            r_drem <= '0;
            r_dcnt <= psw_pkg::DIVC_W'(psw_pkg::TOT_W);
        end else if (i_cmd.div_step) begin
            r_drem <= d_ge ? d_sub : d_t[psw_pkg::CNT_W-1:0];
            r_dq   <= {r_dq[psw_pkg::TOT_W-2:0], d_ge};
            r_dcnt <= r_dcnt - psw_pkg::DIVC_W'(1);
        end
        if (i_cmd.save_w) begin
            r_avg_w <= r_dq;
        end
        if (i_cmd.save_t) begin
            r_avg_t <= r_dq;
        end
        if (i_cmd.emit_init) begin
            r_k   <= '0;
            r_sum <= '0;
        end
        // one result word per ordered job
        if (i_cmd.emit_ld) begin
            r_out.num      <= r_rd.num;
            r_out.len      <= psw_pkg::OUT_LEN_W'(r_rd.len);
            r_out.wait_t   <= psw_pkg::TIME_W'(r_sum);
            r_out.turn_t   <= psw_pkg::TIME_W'(r_sum + psw_pkg::SUM_W'(r_rd.len));
            r_out.wait_avg <= psw_pkg::TIME_W'(r_avg_w);
            r_out.avg_turn <= psw_pkg::TIME_W'(r_avg_t);
            r_out.dropped  <= r_ovf;
            r_out.last     <= o_st.k_last;
            r_sum          <= r_sum + psw_pkg::SUM_W'(r_rd.len);
            r_k            <= r_k + psw_pkg::IDX_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/priority_schedule_wait_times_core.sv
// Non-preemptive priority scheduler: jobs load one word per cycle (up to MAX_JOBS, later jobs
// are dropped and flagged) and the word with tlast closes the set. Input is then held off
// while the set is ordered by descending length with a selection sort over a job memory with
// one write and one read port (each compare reads a place and then compares it, each swap
// writes two places in turn), a totals pass and two restoring divisions sharing one divider.
// Results then leave one word at a time, each read from the job memory and then loaded into
// the output register once it is free, each carrying number, length, wait, turnaround and
// both truncated averages; tlast marks the last one. Loading of the next set resumes as soon
// as the last result is in the output register. No memory clearing pass is needed after reset.
// Depends on psw_pkg, psw_ctrl and psw_dp.

module priority_schedule_wait_times_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [psw_pkg::S_DATA_W-1:0]  s_axis_tdata,   // job_length
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // job_number, length_out, wait_time, turnaround_time, average_wait,
    // average_turnaround, zero pad
    output logic [psw_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic [0:0]                    m_axis_tuser    // dropped_jobs
);

    psw_pkg::t_cmd    cmd;
    psw_pkg::t_status st;
    psw_pkg::t_result res;

    // sequencer
    psw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // storage and arithmetic
    psw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in_valid  (s_axis_tvalid),
        .i_in_len    (s_axis_tdata[psw_pkg::IN_LEN_W-1:0]),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    // result word packing, first field lowest
    assign s_axis_tready = cmd.load_en;
    assign m_axis_tdata  = {(psw_pkg::M_DATA_W - psw_pkg::M_FIELD_W)'(0),
                            res.avg_turn, res.wait_avg, res.turn_t, res.wait_t,
                            res.len, res.num};
    assign m_axis_tlast  = res.last;
    assign m_axis_tuser  = res.dropped;

endmodule

FILE: src/psw_chk.sv
// port-level checks of the priority schedule wait-time block
// bound to priority_schedule_wait_times_core; depends on psw_pkg

module psw_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [psw_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic [0:0]                    m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // closing a set stops loading
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after the closing job");

    // no loading while a set is still being emitted
    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a result run");

    // turnaround is wait plus length
    a_turn_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:43] == 21'(m_axis_tdata[42:22] + m_axis_tdata[21:6]))
        else $error("turnaround differs from wait plus length");

endmodule

bind priority_schedule_wait_times_core psw_chk u_psw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/testbench.sv
// self-checking bench for priority_schedule_wait_times_core: job words in, schedule words out
// expected schedules come from an in-bench selection-sort model; depends on psw_pkg and the core

module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 40;

    // result word layout, lowest field first
    localparam int LEN_LSB  = psw_pkg::NUM_W;
    localparam int WAIT_LSB = LEN_LSB + psw_pkg::OUT_LEN_W;
    localparam int TURN_LSB = WAIT_LSB + psw_pkg::TIME_W;
    localparam int AVGW_LSB = TURN_LSB + psw_pkg::TIME_W;
    localparam int AVGT_LSB = AVGW_LSB + psw_pkg::TIME_W;

    typedef struct {
        logic [psw_pkg::NUM_W-1:0]     num;
        logic [psw_pkg::OUT_LEN_W-1:0] len;
        logic [psw_pkg::TIME_W-1:0]    wait_t;
        logic [psw_pkg::TIME_W-1:0]    turn_t;
        logic [psw_pkg::TIME_W-1:0]    wait_avg;
        logic [psw_pkg::TIME_W-1:0]    avg_turn;
        logic                          dropped;
        logic                          last;
    } t_sched_entry;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [psw_pkg::S_DATA_W-1:0] s_axis_tdata = '0;   // job_length
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // job_number, length_out, wait_time, turnaround_time, average_wait,
    // average_turnaround, zero pad
    logic [psw_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                         m_axis_tlast;
    logic [0:0]                   m_axis_tuser;        // dropped_jobs

    // model of the job store
    logic [psw_pkg::LEN_W-1:0] held_len [psw_pkg::MAX_JOBS];
    logic [psw_pkg::NUM_W-1:0] held_num [psw_pkg::MAX_JOBS];
    int                        held_cnt = 0;
    bit                        jobs_dropped = 1'b0;

    t_sched_entry sched_q [$];
    int           fail_cnt = 0;
    int           cycle_cnt = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           rx_hold_cycles = 0;
    logic         rx_holding = 1'b0;
    event         rx_hold_ev;

    priority_schedule_wait_times_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock, 10 units per period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[priority_schedule_wait_times_core] ERROR");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always begin
        @(rx_hold_ev);
        rx_holding <= 1'b1;
        repeat (rx_hold_cycles) @(posedge i_clk);
        rx_holding <= 1'b0;
    end

    function automatic void note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $error("%s", msg);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
            note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
    endfunction

    // store one job; on the closing job, order the set and queue its schedule
    function automatic void schedule_job(input logic [psw_pkg::IN_LEN_W-1:0] len,
                                         input bit last);
        logic [psw_pkg::LEN_W-1:0] tmp_len;
        logic [psw_pkg::NUM_W-1:0] tmp_num;
        int                        n;
        int                        pos;
        longint unsigned           run;
        longint unsigned           tot_w;
        longint unsigned           tot_t;
        longint unsigned           avg_w;
        longint unsigned           avg_t;
        t_sched_entry              r;
        if (held_cnt < psw_pkg::MAX_JOBS) begin
            held_len[held_cnt] = psw_pkg::LEN_W'(len);
            held_num[held_cnt] = psw_pkg::NUM_W'(held_cnt + 1);
            held_cnt++;
        end else begin
            jobs_dropped = 1'b1;
        end
        if (!last)
            return;
        n = held_cnt;
        // selection sort, first strict maximum goes to each place
        for (int i = 0; i < n; i++) begin
            pos = i;
            for (int j = i + 1; j < n; j++)
                if (held_len[j] > held_len[pos])
                    pos = j;
            tmp_len = held_len[i];
            held_len[i] = held_len[pos];
            held_len[pos] = tmp_len;
            tmp_num = held_num[i];
            held_num[i] = held_num[pos];
            held_num[pos] = tmp_num;
        end
        // totals and truncated averages
        run = 0;
        tot_w = 0;
        tot_t = 0;
        for (int i = 0; i < n; i++) begin
            tot_w += run;
            tot_t += run + held_len[i];
            run += held_len[i];
        end
        avg_w = tot_w / n;
        avg_t = tot_t / n;
        // one schedule word per ordered job
        run = 0;
        for (int i = 0; i < n; i++) begin
            r.num      = held_num[i];
            r.len      = psw_pkg::OUT_LEN_W'(held_len[i]);
            r.wait_t   = psw_pkg::TIME_W'(run);
            r.turn_t   = psw_pkg::TIME_W'(run + held_len[i]);
            r.wait_avg = psw_pkg::TIME_W'(avg_w);
            r.avg_turn = psw_pkg::TIME_W'(avg_t);
            r.dropped  = jobs_dropped;
            r.last     = (i == n - 1);
            sched_q.push_back(r);
            run += held_len[i];
        end
        held_cnt = 0;
        jobs_dropped = 1'b0;
    endfunction

    function automatic void check_schedule_word();
        t_sched_entry want;
        if (sched_q.size() == 0) begin
            note_failure("schedule word with nothing expected");
            return;
        end
        want = sched_q.pop_front();
        compare_field("job_number", want.num, m_axis_tdata[LEN_LSB-1:0]);
        compare_field("length_out", want.len,
                      m_axis_tdata[LEN_LSB +: psw_pkg::OUT_LEN_W]);
        compare_field("wait_time", want.wait_t, m_axis_tdata[WAIT_LSB +: psw_pkg::TIME_W]);
        compare_field("turnaround_time", want.turn_t,
                      m_axis_tdata[TURN_LSB +: psw_pkg::TIME_W]);
        compare_field("average_wait", want.wait_avg,
                      m_axis_tdata[AVGW_LSB +: psw_pkg::TIME_W]);
        compare_field("average_turnaround", want.avg_turn,
                      m_axis_tdata[AVGT_LSB +: psw_pkg::TIME_W]);
        compare_field("dropped_jobs", want.dropped, m_axis_tuser[0]);
        compare_field("final_result", want.last, m_axis_tlast);
    endfunction

    // receiver: check accepted words, then choose next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_schedule_word();
        if (rx_holding)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // offer one job word, returns at the accepting edge with valid still high
    task automatic send_job(input logic [psw_pkg::IN_LEN_W-1:0] len, input bit last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= psw_pkg::S_DATA_W'(len);
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        schedule_job(len, last);
    endtask

    // sender pauses until every expected word has come back
    task automatic drain_schedule();
        s_axis_tvalid <= 1'b0;
        while (sched_q.size() != 0)
            @(posedge i_clk);
    endtask

    // full-range lengths half of the time, plus ties, extremes and near-maximum values
    function automatic logic [psw_pkg::IN_LEN_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return psw_pkg::IN_LEN_W'($urandom);
        else if (roll < 8)
            return psw_pkg::IN_LEN_W'($urandom_range(0, 7));
        else if (roll == 8)
            return ($urandom_range(0, 1) != 0) ? {psw_pkg::IN_LEN_W{1'b1}}
                                               : {psw_pkg::IN_LEN_W{1'b0}};
        else
            return psw_pkg::IN_LEN_W'($urandom_range(2 ** psw_pkg::IN_LEN_W - 64,
                                                     2 ** psw_pkg::IN_LEN_W - 1));
    endfunction

    task automatic send_random_set(input int count);
        for (int i = 0; i < count; i++)
            send_job(pick_length(), i == count - 1);
    endtask

    // one-job sets at the length extremes
    task automatic test_single_jobs();
        tx_idle_pct = 10;
        rx_idle_pct = 20;
        send_job(16'd0, 1'b1);
        send_job(16'hFFFF, 1'b1);
        send_job(16'd1, 1'b1);
        drain_schedule();
    endtask

    // ties, reversed order, bit patterns and equal maxima
    task automatic test_ordering();
        tx_idle_pct = 10;
        rx_idle_pct = 20;
        send_job(16'd3, 1'b0);
        send_job(16'd7, 1'b0);
        send_job(16'd7, 1'b0);
        send_job(16'hAAAA, 1'b0);
        send_job(16'd3, 1'b0);
        send_job(16'h5555, 1'b0);
        send_job(16'd0, 1'b0);
        send_job(16'd7, 1'b1);
        for (int i = 1; i <= 5; i++)
            send_job(psw_pkg::IN_LEN_W'(i), i == 5);
        for (int i = 0; i < 4; i++)
            send_job(16'd4, i == 3);
        send_job(16'hFFFF, 1'b0);
        send_job(16'hFFFF, 1'b1);
        drain_schedule();
    endtask

    // full store at maximum length, then overflow with the closing job dropped
    task automatic test_capacity();
        tx_idle_pct = 5;
        rx_idle_pct = 10;
        for (int i = 0; i < psw_pkg::MAX_JOBS; i++)
            send_job(16'hFFFF, i == psw_pkg::MAX_JOBS - 1);
        send_random_set(psw_pkg::MAX_JOBS + 4);
        // drop flag must clear for the next set
        send_job(16'd9, 1'b1);
        drain_schedule();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
        int sent;
        int set_len;
        int roll;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 19);
            if (roll < 14)
                set_len = $urandom_range(1, 6);
            else if (roll < 18)
                set_len = $urandom_range(7, psw_pkg::MAX_JOBS);
            else if (roll == 18)
                set_len = psw_pkg::MAX_JOBS;
            else
                set_len = $urandom_range(psw_pkg::MAX_JOBS + 1, psw_pkg::MAX_JOBS + 4);
            send_random_set(set_len);
            sent += set_len;
        end
        drain_schedule();
    endtask

    // receiver stalls long enough that loading of later sets backs up
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cycles = 4000;
        -> rx_hold_ev;
        for (int i = 0; i < 3; i++)
            send_random_set(16);
        drain_schedule();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_jobs();
        test_ordering();
        test_capacity();
        test_random_traffic(31, 87, 100);
        test_random_traffic(87, 31, 100);
        test_random_traffic(0, 0, 100);
        test_backpressure();

        // nothing more may show up
        repeat (300) @(posedge i_clk);
        if (sched_q.size() != 0)
            note_failure($sformatf("%0d schedule words never arrived", sched_q.size()));

        if (fail_cnt == 0)
            $display("[priority_schedule_wait_times_core] OK");
        else
            $display("[priority_schedule_wait_times_core] ERROR");
        $finish;
    end

endmodule
